>>> src/cbad_pkg.sv
// Package for the console bus address decoder: types, address map constants
// and the per sub-access decode functions. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package cbad_pkg;

  localparam int MAIN_RAM_BYTES  = 65536;
  localparam int SOUND_RAM_BYTES = 8192;
  localparam int MAIN_AW  = $clog2(MAIN_RAM_BYTES);
  localparam int SOUND_AW = $clog2(SOUND_RAM_BYTES);

  localparam logic [23:0] ROM_END    = 24'h400000;
  localparam logic [23:0] VIDEO_BASE = 24'hC00000;
  localparam logic [23:0] WRAM_BASE  = 24'hE00000;
  localparam logic [7:0]  SOUND_PAGE = 8'hA0;
  localparam logic [7:0]  IO_PAGE    = 8'hA1;
  localparam logic [15:0] STATUS_LO  = 16'h4000;
  localparam logic [15:0] STATUS_HI  = 16'h4003;
  localparam logic [4:0]  VPORT_CTRL = 5'h04;
  localparam logic [4:0]  VPORT_CNT  = 5'h08;
  localparam logic [4:0]  VPORT_NONE = 5'h10;

  typedef enum logic [3:0] {
    TGT_IGNORED = 4'd0,
    TGT_ROM     = 4'd1,
    TGT_IO      = 4'd2,
    TGT_VDATA   = 4'd3,
    TGT_VCTRL   = 4'd4,
    TGT_VCOUNT  = 4'd5,
    TGT_WRAM    = 4'd6,
    TGT_SRAM    = 4'd7,
    TGT_CONST   = 4'd8
  } tgt_e;

  typedef enum logic [1:0] {
    RAM_NONE  = 2'd0,
    RAM_WORK  = 2'd1,
    RAM_SOUND = 2'd2
  } ram_e;

  typedef enum logic [2:0] {
    S_CLR  = 3'd0,
    S_IDLE = 3'd1,
    S_X0   = 3'd2,
    S_X1   = 3'd3,
    S_OUT  = 3'd4
  } st_e;

  // One word or byte operation queued between front and back.
  typedef struct packed {
    logic        wr;
    logic        word;
    logic [23:0] addr;
    logic [15:0] data;
    logic        last;
  } entry_t;

  typedef struct packed {
    tgt_e        tgt;
    logic [15:0] wdata;
    logic [15:0] rdata;
    logic        lane;
    ram_e        ram;
    logic        word;
  } desc_t;

  function automatic logic need_split(entry_t e, logic [22:0] rom);
    logic r;
    r = 1'b0;
    if (e.word) begin
      if (e.addr < ROM_END) begin
        r = !e.wr && (e.addr < {1'b0, rom}) &&
            !(({1'b0, e.addr} + 25'd1) < {2'b00, rom});
      end else if (e.addr >= VIDEO_BASE) begin
        r = 1'b0;
      end else begin
        r = 1'b1;
      end
    end
    return r;
  endfunction

  // Decodes one sub-access. Word sub-accesses only reach here for regions
  // that keep them whole.
  function automatic desc_t decode(logic [23:0] a, logic wr, logic word,
                                   logic [15:0] v, logic [22:0] rom);
    desc_t d;
    logic [15:0] bw;
    logic [15:0] ff;
    tgt_e vt;
    d.tgt   = TGT_IGNORED;
    d.wdata = '0;
    d.rdata = '0;
    d.lane  = 1'b0;
    d.ram   = RAM_NONE;
    d.word  = word;
    bw = word ? v : {8'h00, v[7:0]};
    ff = word ? 16'hFFFF : 16'h00FF;
    if (wr) d.wdata = bw;
    if (a < ROM_END) begin
      if (!wr) begin
        if (word ? (({1'b0, a} + 25'd1) < {2'b00, rom}) : (a < {1'b0, rom})) begin
          d.tgt = TGT_ROM;
        end else begin
          d.tgt   = TGT_CONST;
          d.rdata = ff;
        end
      end
    end else if (a[23:16] == SOUND_PAGE) begin
      if ({1'b0, a[15:0]} < 17'(SOUND_RAM_BYTES)) begin
        d.tgt = TGT_SRAM;
        d.ram = RAM_SOUND;
      end else if (!wr) begin
        d.tgt   = TGT_CONST;
        d.rdata = (a[15:0] >= STATUS_LO && a[15:0] <= STATUS_HI) ? 16'h0000 : 16'h00FF;
      end
    end else if (a[23:16] == IO_PAGE) begin
      d.tgt = TGT_IO;
    end else if (a >= VIDEO_BASE && a < WRAM_BASE) begin
      if (a[4:0] < VPORT_CTRL)      vt = TGT_VDATA;
      else if (a[4:0] < VPORT_CNT)  vt = TGT_VCTRL;
      else if (a[4:0] < VPORT_NONE) vt = TGT_VCOUNT;
      else                          vt = TGT_IGNORED;
      if (wr) begin
        if (vt == TGT_VDATA || vt == TGT_VCTRL) begin
          d.tgt   = vt;
          d.wdata = word ? v : {v[7:0], v[7:0]};
        end
      end else if (vt != TGT_IGNORED) begin
        d.tgt  = vt;
        d.lane = word ? 1'b0 : a[0];
      end else begin
        d.tgt   = TGT_CONST;
        d.rdata = ff;
      end
    end else if (a >= WRAM_BASE) begin
      d.tgt = TGT_WRAM;
      d.ram = RAM_WORK;
    end else if (!wr) begin
      d.tgt   = TGT_CONST;
      d.rdata = ff;
    end
    return d;
  endfunction

endpackage
`default_nettype wire

>>> src/cbad_req_if.sv
// Request channel carrying one CPU bus access.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
interface cbad_req_if;
  logic        valid;
  logic        ready;
  logic        command;
  logic [1:0]  access_size;
  logic [23:0] address;
  logic [31:0] write_value;
  modport source (output valid, command, access_size, address, write_value, input ready);
  modport sink (input valid, command, access_size, address, write_value, output ready);
endinterface
`default_nettype wire

>>> src/cbad_rsp_if.sv
// Response channel carrying one decoded sub-access.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
interface cbad_rsp_if;
  logic        valid;
  logic        ready;
  logic [3:0]  target;
  logic [23:0] target_address;
  logic        word_access;
  logic        is_write;
  logic [15:0] out_write_data;
  logic [15:0] read_data;
  logic        low_byte_lane;
  logic        last;
  modport source (output valid, target, target_address, word_access, is_write,
                  out_write_data, read_data, low_byte_lane, last, input ready);
  modport sink (input valid, target, target_address, word_access, is_write,
                out_write_data, read_data, low_byte_lane, last, output ready);
endinterface
`default_nettype wire

>>> src/cbad_ram.sv
// Generic single-port RAM with registered read data.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
module cbad_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     en_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] addr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  output      logic [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (we_i) mem_q[addr_i] <= wdata_i;
      else      rdata_o <= mem_q[addr_i];
    end
  end
endmodule
`default_nettype wire

>>> src/cbad_front.sv
// Front end: accepts bus accesses, splits longs into two word operations
// and queues them for the back end. Depends on cbad_pkg and cbad_req_if.
`timescale 1ns / 1ps
`default_nettype none
module cbad_front import cbad_pkg::*; (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  en_i,
  cbad_req_if.sink   req,
  output      logic  q_valid_o,
  output      entry_t q_entry_o,
  input  wire logic  q_pop_i
);
  entry_t     fifo_q [2];
  logic       wptr_q, rptr_q;
  logic [1:0] cnt_q;
  entry_t     pend_q;
  logic       pend_vld_q;
  logic       full, push, acc;
  entry_t     push_e, first_e;

  assign full      = (cnt_q == 2'd2);
  assign req.ready = en_i && !pend_vld_q && !full;
  assign acc       = req.valid && req.ready;
  assign q_valid_o = (cnt_q != 2'd0);
  assign q_entry_o = fifo_q[rptr_q];

  always_comb begin
    first_e.wr   = req.command;
    first_e.addr = req.address;
    first_e.word = (req.access_size != 2'd0);
    first_e.last = 1'b1;
    first_e.data = req.write_value[15:0];
    if (req.access_size == 2'd0) begin
      first_e.data = {8'h00, req.write_value[7:0]};
    end else if (req.access_size[1]) begin
      first_e.data = req.write_value[31:16];
      first_e.last = 1'b0;
    end
    push   = acc || (pend_vld_q && !full);
    push_e = pend_vld_q ? pend_q : first_e;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q     <= 1'b0;
      rptr_q     <= 1'b0;
      cnt_q      <= 2'd0;
      pend_vld_q <= 1'b0;
    end else begin
      if (push) wptr_q <= !wptr_q;
      if (q_pop_i) rptr_q <= !rptr_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, q_pop_i};
      if (acc && req.access_size[1]) pend_vld_q <= 1'b1;
      else if (pend_vld_q && !full) pend_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) fifo_q[wptr_q] <= push_e;
    if (acc) begin
      pend_q.wr   <= req.command;
      pend_q.word <= 1'b1;
      pend_q.addr <= req.address + 24'd2;
      pend_q.data <= req.write_value[15:0];
      pend_q.last <= 1'b1;
    end
  end
endmodule
`default_nettype wire

>>> src/cbad_back.sv
// Back end: clears both RAMs after reset, then decodes queued operations into
// sub-accesses and drives the response register. Depends on cbad_pkg,
// cbad_ram and cbad_rsp_if.
`timescale 1ns / 1ps
`default_nettype none
module cbad_back import cbad_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic [22:0] rom_limit_i,
  input  wire logic        q_valid_i,
  input  wire entry_t      q_entry_i,
  output      logic        q_pop_o,
  output      logic        busy_o,
  cbad_rsp_if.source       rsp
);
  st_e                 state_q, state_d;
  entry_t              ent_q, ent_d;
  logic                split_q, split_d, part_q, part_d;
  logic [7:0]          hi_q, hi_d;
  logic [MAIN_AW-1:0]  clr_q, clr_d;
  logic                out_vld_q, out_free, load;
  logic [23:0]         cur_addr, nxt_addr;
  logic [15:0]         cur_v, rd_data;
  desc_t               desc;
  logic                w_en, w_we, s_en, s_we;
  logic [MAIN_AW-1:0]  w_addr;
  logic [SOUND_AW-1:0] s_addr;
  logic [7:0]          w_wdata, s_wdata, w_rd, s_rd;

  cbad_ram #(.WIDTH(8), .DEPTH(MAIN_RAM_BYTES)) u_wram (
    .clk_i, .en_i(w_en), .we_i(w_we), .addr_i(w_addr), .wdata_i(w_wdata), .rdata_o(w_rd));
  cbad_ram #(.WIDTH(8), .DEPTH(SOUND_RAM_BYTES)) u_sram (
    .clk_i, .en_i(s_en), .we_i(s_we), .addr_i(s_addr), .wdata_i(s_wdata), .rdata_o(s_rd));

  assign cur_addr = ent_q.addr + {23'd0, split_q & part_q};
  assign nxt_addr = cur_addr + 24'd1;
  assign cur_v    = !split_q ? ent_q.data :
                    (part_q ? {8'h00, ent_q.data[7:0]} : {8'h00, ent_q.data[15:8]});
  assign desc     = decode(cur_addr, ent_q.wr, ent_q.word & !split_q, cur_v, rom_limit_i);
  assign out_free = !out_vld_q || rsp.ready;
  assign busy_o   = (state_q == S_CLR);
  assign rsp.valid = out_vld_q;

  always_comb begin
    rd_data = desc.rdata;
    if (!ent_q.wr && desc.ram == RAM_WORK) rd_data = desc.word ? {hi_q, w_rd} : {8'h00, w_rd};
    if (!ent_q.wr && desc.ram == RAM_SOUND) rd_data = {8'h00, s_rd};
  end

  always_comb begin
    state_d = state_q;
    ent_d   = ent_q;
    split_d = split_q;
    part_d  = part_q;
    hi_d    = hi_q;
    clr_d   = clr_q;
    q_pop_o = 1'b0;
    load    = 1'b0;
    w_en    = 1'b0;
    w_we    = ent_q.wr;
    w_addr  = cur_addr[MAIN_AW-1:0];
    w_wdata = desc.word ? cur_v[15:8] : cur_v[7:0];
    s_en    = 1'b0;
    s_we    = ent_q.wr;
    s_addr  = cur_addr[SOUND_AW-1:0];
    s_wdata = cur_v[7:0];
    case (state_q)
      S_CLR: begin
        w_en    = 1'b1;
        w_we    = 1'b1;
        w_addr  = clr_q;
        w_wdata = 8'h00;
        s_en    = 1'b1;
        s_we    = 1'b1;
        s_addr  = clr_q[SOUND_AW-1:0];
        s_wdata = 8'h00;
        clr_d   = clr_q + MAIN_AW'(1);
        if (&clr_q) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (q_valid_i) begin
          q_pop_o = 1'b1;
          ent_d   = q_entry_i;
          split_d = need_split(q_entry_i, rom_limit_i);
          part_d  = 1'b0;
          state_d = S_X0;
        end
      end
      S_X0: begin
        w_en    = (desc.ram == RAM_WORK);
        s_en    = (desc.ram == RAM_SOUND);
        state_d = (desc.ram == RAM_WORK && desc.word) ? S_X1 : S_OUT;
      end
      S_X1: begin
        // Second byte of a work RAM word wraps inside the 64 KB window.
        hi_d    = w_rd;
        w_en    = 1'b1;
        w_addr  = nxt_addr[MAIN_AW-1:0];
        w_wdata = cur_v[7:0];
        state_d = S_OUT;
      end
      S_OUT: begin
        if (out_free) begin
          load = 1'b1;
          if (split_q && !part_q) begin
            part_d  = 1'b1;
            state_d = S_X0;
          end else begin
            state_d = S_IDLE;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_CLR;
      clr_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      if (load) out_vld_q <= 1'b1;
      else if (rsp.ready) out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    ent_q   <= ent_d;
    split_q <= split_d;
    part_q  <= part_d;
    hi_q    <= hi_d;
    if (load) begin
      rsp.target         <= desc.tgt;
      rsp.target_address <= cur_addr;
      rsp.word_access    <= desc.word;
      rsp.is_write       <= ent_q.wr;
      rsp.out_write_data <= desc.wdata;
      rsp.read_data      <= ent_q.wr ? 16'h0000 : rd_data;
      rsp.low_byte_lane  <= desc.lane;
      rsp.last           <= ent_q.last && !(split_q && !part_q);
    end
  end

  a_no_rsp_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_CLR |-> !out_vld_q) else $error("response during RAM clear");
  a_x1_work_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_X1 |-> (desc.ram == RAM_WORK && desc.word))
    else $error("second RAM cycle outside a work RAM word");
  a_load_from_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_vld_q) |-> $past(state_q == S_OUT)) else $error("response loaded out of order");
  a_pop_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop_o |-> (state_q == S_IDLE && q_valid_i)) else $error("pop without entry");
endmodule
`default_nettype wire

>>> src/console_bus_address_decoder.sv
// Top level of the console bus address decoder.
// Depends on cbad_pkg, cbad_req_if, cbad_rsp_if, cbad_front and cbad_back.
//
// The req channel takes one CPU bus access per transfer; the rsp channel gives
// one decoded sub-access per transfer, with last set on the final one of each
// access. A long access gives two word sub-accesses, and word accesses to
// sound space, I/O or unmapped space (and ROM word reads straddling rom_limit)
// give two byte sub-accesses, so one access yields one to four transfers.
// rom_limit is written with rom_limit_we_i high; the user must write it only
// while the block is idle, which the block itself does not enforce. The back
// end handles each sub-access in S_X0, which drives any RAM access, and
// S_OUT, which loads the response register, with S_X1 between them for a
// work RAM word, whose two bytes share the one RAM port. A two-entry queue
// sits between front and back, so requests keep being taken while the back
// works. After reset both internal RAMs are cleared, one address a cycle,
// over the 65536 work RAM addresses; req.ready stays low until that is done.
// If the receiver stalls, the response register holds and the back end waits.
`timescale 1ns / 1ps
`default_nettype none
module console_bus_address_decoder import cbad_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        rom_limit_we_i,
  input  wire logic [22:0] rom_limit_i,
  cbad_req_if.sink         req,
  cbad_rsp_if.source       rsp
);
  logic [22:0] rom_q;
  logic        q_valid, q_pop, busy;
  entry_t      q_entry;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) rom_q <= '0;
    else if (rom_limit_we_i) rom_q <= rom_limit_i;
  end

  cbad_front u_front (
    .clk_i, .rst_ni, .en_i(!busy), .req,
    .q_valid_o(q_valid), .q_entry_o(q_entry), .q_pop_i(q_pop));

  cbad_back u_back (
    .clk_i, .rst_ni, .rom_limit_i(rom_q), .q_valid_i(q_valid), .q_entry_i(q_entry),
    .q_pop_o(q_pop), .busy_o(busy), .rsp);
endmodule
`default_nettype wire
